// ===== src/its_pkg.sv =====
`timescale 1ns / 1ps
// package for the interval timer statistics core
// state type of the controller; command and status types shared by controller and datapath; no dependencies
package its_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STOP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_COMMIT,
    ST_DONE
  } its_state_t;

  typedef struct packed {
    logic capture;
    logic mul_step;
    logic add_dur;
    logic div_step;
    logic commit;
    logic load_out;
  } its_cmd_t;

  typedef struct packed {
    logic long_path;
  } its_status_t;

endpackage

// ===== src/its_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the interval timer statistics core
// depends on its_pkg; drives commands into its_datapath
module its_ctrl
  import its_pkg::*;
#(
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  its_status_t stat,
  output its_cmd_t    cmd
);

  localparam int MAX_STEPS = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  its_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = stat.long_path ? ST_MUL : ST_COMMIT;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(COUNT_WIDTH - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_dur = 1'b1;
        cnt_next    = '0;
        state_next  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(TIME_WIDTH - 1)) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/its_datapath.sv =====
`timescale 1ns / 1ps
// datapath of the interval timer statistics core: statistics registers,
// shift-add multiplier, restoring divider and output register; depends on its_pkg
module its_datapath
  import its_pkg::*;
#(
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  its_cmd_t                                cmd,
  output its_status_t                             stat,
  input  logic [((TIME_WIDTH+7)/8)*8-1:0]         s_tdata,
  input  logic                                    s_tuser,
  output logic [COUNT_WIDTH+3*TIME_WIDTH-1:0]     m_tdata,
  output logic                                    m_tuser
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = COUNT_WIDTH;

  logic [TW-1:0]    timestamp;
  logic [TW-1:0]    start_time, mean_value, least_value, greatest_value;
  logic             start_valid;
  logic [CW-1:0]    event_count;
  logic [TW-1:0]    dur, hi, quo;
  logic [CW-1:0]    lo;
  logic [CW:0]      rem, divisor;
  logic             op_stop, take;
  logic [TW:0]      mul_sum;
  logic [TW+CW-1:0] numer;
  logic [CW+1:0]    trial, diff;

  assign timestamp      = s_tdata[TW-1:0];
  assign stat.long_path = (s_tuser == OP_STOP) && start_valid && (start_time <= timestamp);

  assign mul_sum = {1'b0, hi} + {1'b0, (lo[0] ? mean_value : {TW{1'b0}})};
  assign numer   = {hi, lo} + {{CW{1'b0}}, dur};
  assign divisor = {1'b0, event_count} + {{CW{1'b0}}, 1'b1};
  assign trial   = {rem, quo[TW-1]};
  assign diff    = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time     <= '0;
      start_valid    <= 1'b0;
      event_count    <= '0;
      mean_value     <= '0;
      least_value    <= '1;
      greatest_value <= '0;
    end else begin
      if (cmd.capture && s_tuser == OP_START) begin
        start_time  <= timestamp;
        start_valid <= 1'b1;
      end
      if (cmd.commit) begin
        if (take) begin
          mean_value <= quo;
          if (dur < least_value) begin
            least_value <= dur;
          end
          if (dur > greatest_value) begin
            greatest_value <= dur;
          end
        end
        if (op_stop && event_count != {CW{1'b1}}) begin
          event_count <= event_count + 1'b1;
        end
      end
    end
  end

  // multiplier and divider working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_stop <= (s_tuser == OP_STOP);
      take    <= stat.long_path;
      dur     <= timestamp - start_time;
      hi      <= '0;
      lo      <= event_count;
    end
    if (cmd.mul_step) begin
      {hi, lo} <= {mul_sum, lo[CW-1:1]};
    end
    if (cmd.add_dur) begin
      rem <= {1'b0, numer[TW+CW-1:TW]};
      quo <= numer[TW-1:0];
    end
    if (cmd.div_step) begin
      rem <= diff[CW+1] ? trial[CW:0] : diff[CW:0];
      quo <= {quo[TW-2:0], !diff[CW+1]};
    end
    if (cmd.load_out) begin
      m_tdata <= {greatest_value, least_value, mean_value, event_count};
      m_tuser <= take;
    end
  end

endmodule

// ===== src/interval_timer_statistics_core.sv =====
`timescale 1ns / 1ps
// interval timer statistics core, top level; depends on its_pkg, its_ctrl, its_datapath
// a timed stop runs the shift-add multiplier over every bit of the count, adds the
// duration, then runs the restoring divider one quotient bit per step; start events
// and untimed stops go straight to commit; the result becomes valid in the same cycle
// that s_tready returns; rst is synchronous and active high: statistics cleared, minimum set to all ones
module interval_timer_statistics_core
  import its_pkg::*;
#(
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((TIME_WIDTH+7)/8)*8-1:0]     s_tdata,  // timestamp
  input  logic                                s_tuser,  // operation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sample_count, average_duration, minimum_duration, maximum_duration
  output logic [COUNT_WIDTH+3*TIME_WIDTH-1:0] m_tdata,
  output logic                                m_tuser   // sample_valid
);

  its_cmd_t    cmd;
  its_status_t stat;

  its_ctrl #(
    .TIME_WIDTH (TIME_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  its_datapath #(
    .TIME_WIDTH (TIME_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

endmodule

// ===== src/its_checker.sv =====
`timescale 1ns / 1ps
// port checker for the interval timer statistics core
// bound to interval_timer_statistics_core; no package dependencies
module its_checker #(
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [COUNT_WIDTH+3*TIME_WIDTH-1:0] m_tdata,
  input logic                                m_tuser
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = COUNT_WIDTH;

  logic [CW-1:0] cnt_f;
  logic [TW-1:0] min_f, max_f;

  assign cnt_f = m_tdata[CW-1:0];
  assign min_f = m_tdata[CW+2*TW-1:CW+TW];
  assign max_f = m_tdata[CW+3*TW-1:CW+2*TW];

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> min_f <= max_f)
    else $error("minimum above maximum after a sample");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> cnt_f != '0)
    else $error("sample reported with zero count");

endmodule

bind interval_timer_statistics_core its_checker #(
  .TIME_WIDTH (TIME_WIDTH),
  .COUNT_WIDTH(COUNT_WIDTH)
) u_its_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
